### hw/rtl/assert_macros.svh
// Assertion macros shared by the spectral taper mask RTL.
// Users must provide clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked on clk_i, disabled while reset is low.
`define SBTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sbtm assertion failed");

// Same-cycle implication, clocked on clk_i, disabled while reset is low.
`define SBTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbtm implication failed");

`endif

### hw/rtl/sbtm_pkg.sv
// Package for the spectral taper mask: types, constants and the Q30 product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbtm_pkg;

  localparam int CFG_W    = 9;
  localparam int ADDR_W   = 5;
  localparam int PART_N   = 6;
  // Prep stage, one stage per quotient bit, six polynomial stages.
  localparam int DIV_BITS = 31;
  localparam int LANE_LAT = 1 + DIV_BITS + 6;

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [62:0] MUL30_RND = 63'd536870912;

  // Odd sine series coefficients in Q30.
  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  typedef enum logic [2:0] {
    REG_MASK_X, REG_MASK_Y, REG_MASK_Z, REG_ZERO_X, REG_ZERO_Y, REG_ZERO_Z
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] mask_x;
    logic [CFG_W-1:0] mask_y;
    logic [CFG_W-1:0] mask_z;
    logic [CFG_W-1:0] zero_x;
    logic [CFG_W-1:0] zero_y;
    logic [CFG_W-1:0] zero_z;
  } cfg_t;

  // Vector parts in order real_x, imag_x, real_y, imag_y, real_z, imag_z.
  typedef logic [PART_N-1:0][31:0] part_arr_t;

  // Rounded Q30 product: (a*b + 2^29) >> 30.
  function automatic logic [31:0] mul30(input logic [30:0] a, input logic [30:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + MUL30_RND;
    return p[61:30];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sbtm_if.sv
// Stream interfaces for the spectral taper mask: input beats and result beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sbtm_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  index_z;
  logic signed [31:0] real_x;
  logic signed [31:0] imag_x;
  logic signed [31:0] real_y;
  logic signed [31:0] imag_y;
  logic signed [31:0] real_z;
  logic signed [31:0] imag_z;

  modport source (output valid, index_x, index_y, index_z, real_x, imag_x,
                  real_y, imag_y, real_z, imag_z, input ready);
  modport sink (input valid, index_x, index_y, index_z, real_x, imag_x,
                real_y, imag_y, real_z, imag_z, output ready);
endinterface

interface sbtm_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_real_x;
  logic signed [31:0] out_imag_x;
  logic signed [31:0] out_real_y;
  logic signed [31:0] out_imag_y;
  logic signed [31:0] out_real_z;
  logic signed [31:0] out_imag_z;
  logic [15:0] total_weight;

  modport source (output valid, out_real_x, out_imag_x, out_real_y, out_imag_y,
                  out_real_z, out_imag_z, total_weight, input ready);
  modport sink (input valid, out_real_x, out_imag_x, out_real_y, out_imag_y,
                out_real_z, out_imag_z, total_weight, output ready);
endinterface

`default_nettype wire

### hw/rtl/sbtm_cfg.sv
// APB register file holding band widths and zero counts for the three axes.
// Depends on sbtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbtm_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbtm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output sbtm_pkg::cfg_t             cfg_o
);
  import sbtm_pkg::*;

  cfg_t             cfg_q;
  cfg_t             cfg_d;
  logic             wr_en;
  logic [CFG_W-1:0] rd_val;
  logic [CFG_W-1:0] wr_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[CFG_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:2])
        REG_MASK_X: cfg_d.mask_x = wr_val;
        REG_MASK_Y: cfg_d.mask_y = wr_val;
        REG_MASK_Z: cfg_d.mask_z = wr_val;
        REG_ZERO_X: cfg_d.zero_x = wr_val;
        REG_ZERO_Y: cfg_d.zero_y = wr_val;
        REG_ZERO_Z: cfg_d.zero_z = wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MASK_X: rd_val = cfg_q.mask_x;
      REG_MASK_Y: rd_val = cfg_q.mask_y;
      REG_MASK_Z: rd_val = cfg_q.mask_z;
      REG_ZERO_X: rd_val = cfg_q.zero_x;
      REG_ZERO_Y: rd_val = cfg_q.zero_y;
      REG_ZERO_Z: rd_val = cfg_q.zero_z;
      default:    rd_val = '0;
    endcase
  end

  assign prdata = 32'(rd_val);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sbtm_axis_lane.sv
// One axis weight lane: band classification, pipelined divider and
// cos^2 polynomial, giving a Q1.15 weight. Depends on sbtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbtm_axis_lane #(
  parameter int SIZE = 256,
  parameter bit HALF = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [7:0]                index_i,
  input  logic [sbtm_pkg::CFG_W-1:0] mask_i,
  input  logic [sbtm_pkg::CFG_W-1:0] zero_i,
  output logic [15:0]               weight_o
);
  import sbtm_pkg::*;

  localparam int CW = $clog2(SIZE + 1024) + 1;
  localparam logic signed [CW-1:0] CTR = CW'(SIZE / 2);

  typedef struct packed {
    logic [7:0]  rem;
    logic [30:0] num;
    logic [30:0] quo;
    logic [7:0]  h;
    logic        past;
    logic        fixed;
    logic        fix_one;
  } dstage_t;

  typedef struct packed {
    logic [30:0] g;
    logic [30:0] g2;
    logic [30:0] s;
    logic        past;
    logic        fixed;
    logic        fix_one;
  } pstage_t;

  // One restoring division step: one quotient bit per stage.
  function automatic dstage_t div_step(input dstage_t s);
    dstage_t    r;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;
    r     = s;
    trial = {s.rem, s.num[30]};
    diff  = trial - {1'b0, s.h};
    ge    = trial >= {1'b0, s.h};
    r.rem = ge ? diff[7:0] : trial[7:0];
    r.quo = {s.quo[29:0], ge};
    r.num = {s.num[29:0], 1'b0};
    return r;
  endfunction

  // Copy of a polynomial stage with a new partial sum.
  function automatic pstage_t set_s(input pstage_t p, input logic [30:0] s);
    pstage_t r;
    r   = p;
    r.s = s;
    return r;
  endfunction

  // Band classification.
  logic [CFG_W-1:0]       hdiff;
  logic [7:0]             h8;
  logic signed [CW-1:0]   iv, hv, nv, lo_z, hi_z, lo_t, hi_t, tv;
  logic                   in_zero, in_fall, in_rise;
  logic [7:0]             t8;
  logic signed [9:0]      dv;
  logic [9:0]             adv_abs;
  logic [7:0]             a8;
  dstage_t                prep;

  always_comb begin
    hdiff   = (mask_i > zero_i) ? (mask_i - zero_i) : '0;
    h8      = hdiff[8:1];
    iv      = CW'(index_i);
    hv      = CW'(h8);
    nv      = CW'(zero_i[8:1]);
    lo_z    = CTR - nv;
    hi_z    = CTR + nv;
    lo_t    = lo_z - hv;
    hi_t    = hi_z + hv;
    in_zero = (iv >= lo_z) && (iv < hi_z);
    in_fall = (iv >= lo_t) && (iv < lo_z);
    in_rise = !HALF && (iv >= hi_z) && (iv < hi_t);
    tv      = in_fall ? (iv - lo_t) : (hi_t - iv);
    t8      = tv[7:0];
    dv      = $signed({2'b00, h8}) - $signed({1'b0, t8, 1'b0});
    adv_abs = dv[9] ? (10'd0 - dv) : dv;
    a8      = adv_abs[7:0];

    prep.h       = h8;
    prep.past    = dv[9];
    prep.quo     = '0;
    // Dividend is a*2^30 + h/2; the top eight bits start the remainder.
    prep.rem     = {1'b0, a8[7:1]};
    prep.num     = {a8[0], 23'd0, h8[7:1]};
    prep.fixed   = (mask_i == '0) || in_zero || !(in_fall || in_rise);
    prep.fix_one = (mask_i == '0) || !in_zero;
  end

  dstage_t dv_q [0:DIV_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0] <= prep;
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1] <= div_step(dv_q[j]);
      end
    end
  end

  // Polynomial stages: square, four Horner steps, final product.
  pstage_t ps_q [0:4];
  logic [15:0] weight_q;
  logic [31:0] sq, h9, h7, h5, h3, sfin;
  logic [30:0] sclip;
  logic [31:0] tsum, trnd;

  assign sq = mul30(dv_q[DIV_BITS].quo, dv_q[DIV_BITS].quo);
  assign h9 = mul30(ps_q[0].g2, C9);
  assign h7 = mul30(ps_q[1].g2, ps_q[1].s);
  assign h5 = mul30(ps_q[2].g2, ps_q[2].s);
  assign h3 = mul30(ps_q[3].g2, ps_q[3].s);
  assign sfin = mul30(ps_q[4].s, ps_q[4].g);

  always_comb begin
    sclip = (sfin > 32'(Q30_ONE)) ? Q30_ONE : sfin[30:0];
    tsum  = ps_q[4].past ? (32'(Q30_ONE) - 32'(sclip)) : (32'(Q30_ONE) + 32'(sclip));
    trnd  = tsum + 32'd32768;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps_q[0].g       <= dv_q[DIV_BITS].quo;
      ps_q[0].g2      <= sq[30:0];
      ps_q[0].s       <= '0;
      ps_q[0].past    <= dv_q[DIV_BITS].past;
      ps_q[0].fixed   <= dv_q[DIV_BITS].fixed;
      ps_q[0].fix_one <= dv_q[DIV_BITS].fix_one;

      ps_q[1] <= set_s(ps_q[0], C7 - h9[30:0]);
      ps_q[2] <= set_s(ps_q[1], C5 - h7[30:0]);
      ps_q[3] <= set_s(ps_q[2], C3 - h5[30:0]);
      ps_q[4] <= set_s(ps_q[3], C1 - h3[30:0]);

      if (ps_q[4].fixed) begin
        weight_q <= ps_q[4].fix_one ? ONE_Q15 : 16'd0;
      end else begin
        weight_q <= trnd[31:16];
      end
    end
  end

  assign weight_o = weight_q;

endmodule

`default_nettype wire

### hw/rtl/sbtm_merge.sv
// Merge stage: multiplies the three lane weights and scales the six parts,
// with the output register. Depends on sbtm_pkg and sbtm_if.
`timescale 1ns / 1ps
`default_nettype none

module sbtm_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [15:0]         wx_i,
  input  logic [15:0]         wy_i,
  input  logic [15:0]         wz_i,
  input  sbtm_pkg::part_arr_t parts_i,
  output logic                adv_o,
  sbtm_out_if.source          out_o
);
  import sbtm_pkg::*;

  logic        m1_vld_q, m2_vld_q, o_vld_q;
  logic [15:0] wxy_q, wz1_q, w2_q, wo_q;
  part_arr_t   parts1_q, mag2_q, res_q;
  logic [PART_N-1:0] neg2_q;

  logic [31:0] pxy, pw;
  logic [47:0] prod [PART_N];
  logic [47:0] prnd [PART_N];
  part_arr_t   res_d;

  assign adv_o = !o_vld_q || out_o.ready;

  assign pxy = wx_i * wy_i + 32'd16384;
  assign pw  = wxy_q * wz1_q + 32'd16384;

  always_comb begin
    for (int k = 0; k < PART_N; k++) begin
      prod[k]  = 48'(mag2_q[k]) * 48'(w2_q);
      prnd[k]  = prod[k] + 48'd16384;
      res_d[k] = neg2_q[k] ? (32'd0 - prnd[k][46:15]) : prnd[k][46:15];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (adv_o) begin
      m1_vld_q <= vld_i;
      m2_vld_q <= m1_vld_q;
      o_vld_q  <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      wxy_q    <= pxy[30:15];
      wz1_q    <= wz_i;
      parts1_q <= parts_i;
      w2_q     <= pw[30:15];
      for (int k = 0; k < PART_N; k++) begin
        neg2_q[k] <= parts1_q[k][31];
        mag2_q[k] <= parts1_q[k][31] ? (32'd0 - parts1_q[k]) : parts1_q[k];
      end
      wo_q  <= w2_q;
      res_q <= res_d;
    end
  end

  assign out_o.valid        = o_vld_q;
  assign out_o.out_real_x   = res_q[0];
  assign out_o.out_imag_x   = res_q[1];
  assign out_o.out_real_y   = res_q[2];
  assign out_o.out_imag_y   = res_q[3];
  assign out_o.out_real_z   = res_q[4];
  assign out_o.out_imag_z   = res_q[5];
  assign out_o.total_weight = wo_q;

endmodule

`default_nettype wire

### hw/rtl/spectral_band_taper_mask.sv
// Top level of the spectral taper mask: register file, three axis lanes
// and the merge stage. Depends on sbtm_pkg, sbtm_if and assert_macros.svh.
//
//  Channel | Direction | Beat contents
//  --------+-----------+----------------------------------------------------
//  in_i    | sink      | index_x/y/z, real/imag parts of the x, y, z component
//  out_o   | source    | scaled parts out_real_x .. out_imag_z, total_weight
//  APB     | slave     | six 9-bit registers at byte addresses 0, 4, .. 20
//
// A new beat is taken every cycle while the output is not stalled; a beat passes
// through the lane pipeline (one prep stage, 31 divider stages, six polynomial
// stages) and then three merge stages.
// The whole pipeline advances together; it freezes only while a result sits in
// the output register and the sink is not ready, so ready follows that state.
// Reset clears the configuration registers and all valid bits; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spectral_band_taper_mask #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 256,
  parameter int GRID_Z = 129
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sbtm_in_if.sink                    in_i,
  sbtm_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbtm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sbtm_pkg::*;

  cfg_t        cfg;
  logic        adv;
  logic        acc;
  logic [15:0] wx, wy, wz;

  // Valid bits and payload travel alongside the lanes.
  logic [LANE_LAT-1:0] lv_q;
  part_arr_t           par_q [0:LANE_LAT-1];
  part_arr_t           par_in;

  sbtm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;

  assign par_in = {in_i.imag_z, in_i.real_z, in_i.imag_y, in_i.real_y,
                   in_i.imag_x, in_i.real_x};

  // The x and y axes cover a full spectrum; z is a half spectrum and so has
  // only the lower taper band.
  sbtm_axis_lane #(.SIZE(GRID_X), .HALF(1'b0)) u_lane_x (
    .clk_i (clk_i), .en_i (adv), .index_i (in_i.index_x),
    .mask_i (cfg.mask_x), .zero_i (cfg.zero_x), .weight_o (wx)
  );

  sbtm_axis_lane #(.SIZE(GRID_Y), .HALF(1'b0)) u_lane_y (
    .clk_i (clk_i), .en_i (adv), .index_i (in_i.index_y),
    .mask_i (cfg.mask_y), .zero_i (cfg.zero_y), .weight_o (wy)
  );

  sbtm_axis_lane #(.SIZE(GRID_Z), .HALF(1'b1)) u_lane_z (
    .clk_i (clk_i), .en_i (adv), .index_i (in_i.index_z),
    .mask_i (cfg.mask_z), .zero_i (cfg.zero_z), .weight_o (wz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
    end else if (adv) begin
      lv_q <= {lv_q[LANE_LAT-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      par_q[0] <= par_in;
      for (int k = 1; k < LANE_LAT; k++) begin
        par_q[k] <= par_q[k-1];
      end
    end
  end

  sbtm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (lv_q[LANE_LAT-1]),
    .wx_i    (wx),
    .wy_i    (wy),
    .wz_i    (wz),
    .parts_i (par_q[LANE_LAT-1]),
    .adv_o   (adv),
    .out_o   (out_o)
  );

  // A combined weight never exceeds one.
  `SBTM_ASSERT_IMP(a_weight_max, out_o.valid, out_o.total_weight <= ONE_Q15)
  // A zero weight must wipe the vector; checked here on out_real_x and out_imag_z.
  `SBTM_ASSERT_IMP(a_zero_wipe, out_o.valid && (out_o.total_weight == 16'd0), out_o.out_real_x == 32'sd0 && out_o.out_imag_z == 32'sd0)
  // While the output is stalled no beat moves inside the lanes.
  `SBTM_ASSERT(a_stall_hold, !adv |=> $stable(lv_q))

endmodule

`default_nettype wire

### sim/tb_spectral_band_taper_mask.sv
// Self-checking testbench for the spectral band taper mask: drives element beats,
// programs the six APB registers between phases and checks every result beat.
// Depends on sbtm_pkg, sbtm_if and the spectral_band_taper_mask RTL.
`timescale 1ns / 1ps

module tb_spectral_band_taper_mask;
  import sbtm_pkg::*;

  localparam int unsigned GRID_X = 256;
  localparam int unsigned GRID_Y = 256;
  localparam int unsigned GRID_Z = 129;
  // Extra clocks that let the pipeline run dry once every expected beat is back.
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1950;
  localparam logic [63:0] TAP_C1 = 64'd1686629713;
  localparam logic [63:0] TAP_C3 = 64'd693598668;
  localparam logic [63:0] TAP_C5 = 64'd85569306;
  localparam logic [63:0] TAP_C7 = 64'd5026995;
  localparam logic [63:0] TAP_C9 = 64'd172272;
  localparam logic [63:0] Q30_UNIT = 64'd1073741824;

  // One element beat as driven on the input channel.
  typedef struct {
    logic [7:0]  ix;
    logic [7:0]  iy;
    logic [7:0]  iz;
    logic [31:0] part [6];
  } elem_t;

  // One scaled result beat.
  typedef struct {
    logic [31:0] part [6];
    logic [15:0] weight;
  } scaled_t;

  // Directed row: an element plus an optional hand-written expected weight.
  typedef struct {
    elem_t       elem;
    bit          has_weight;
    logic [15:0] weight;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sbtm_in_if  elem_ch ();
  sbtm_out_if scaled_ch ();

  spectral_band_taper_mask #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)
  ) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(elem_ch.sink), .out_o(scaled_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the mask registers, used by the weight predictor.
  logic [8:0] mask_w [3];
  logic [8:0] zero_n [3];

  scaled_t expected_beats [$];
  int mismatch_count = 0;
  int beats_checked = 0;
  int elems_sent = 0;
  longint cycle_count = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  // ---------------------------------------------------------------------
  // Weight predictor.
  // ---------------------------------------------------------------------

  // Rounded Q30 product.
  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // cos^2 taper for offset t within a band of half width h, in Q1.15.
  function automatic logic [15:0] cos2_taper(input int t, input int h);
    int d;
    bit past;
    logic [63:0] g, g2, s, tot;
    d = h - 2 * t;
    past = d < 0;
    g = (((64'(past ? -d : d)) << 30) + 64'(h / 2)) / 64'(h);
    g2 = q30_mul(g, g);
    s = TAP_C7 - q30_mul(g2, TAP_C9);
    s = TAP_C5 - q30_mul(g2, s);
    s = TAP_C3 - q30_mul(g2, s);
    s = TAP_C1 - q30_mul(g2, s);
    s = q30_mul(s, g);
    if (s > Q30_UNIT) s = Q30_UNIT;
    tot = past ? Q30_UNIT - s : Q30_UNIT + s;
    return 16'((tot + 64'd32768) >> 16);
  endfunction

  // Weight of one axis for one index. The z axis is a half spectrum, so it
  // only has the falling band below the centre.
  function automatic logic [15:0] axis_weight(input logic [7:0] idx, input int grid,
                                             input logic [8:0] m, input logic [8:0] zc,
                                             input bit half);
    int h, n, c, i;
    if (m == 0) return ONE_Q15;
    h = (m > zc) ? (int'(m) - int'(zc)) / 2 : 0;
    n = int'(zc) / 2;
    c = grid / 2;
    i = int'(idx);
    if (i >= c - n && i < c + n) return 16'd0;
    if (i >= c - h - n && i < c - n) return cos2_taper(i - (c - h - n), h);
    if (!half && i >= c + n && i < c + h + n) return cos2_taper((c + h + n) - i, h);
    return ONE_Q15;
  endfunction

  // Scales one Q16.16 part by the weight, rounding half away from zero.
  function automatic logic [31:0] scale_part(input logic [31:0] v, input logic [15:0] w);
    logic [63:0] mag, p;
    mag = v[31] ? (64'h1_0000_0000 - 64'(v)) : 64'(v);
    p = (mag * 64'(w) + 64'd16384) >> 15;
    return v[31] ? 32'(64'h1_0000_0000 - p) : 32'(p);
  endfunction

  function automatic scaled_t predict_scaled(input elem_t e);
    scaled_t r;
    logic [63:0] w;
    w = 64'(axis_weight(e.ix, GRID_X, mask_w[0], zero_n[0], 1'b0));
    w = (w * 64'(axis_weight(e.iy, GRID_Y, mask_w[1], zero_n[1], 1'b0)) + 64'd16384) >> 15;
    w = (w * 64'(axis_weight(e.iz, GRID_Z, mask_w[2], zero_n[2], 1'b1)) + 64'd16384) >> 15;
    r.weight = 16'(w);
    foreach (r.part[k]) r.part[k] = scale_part(e.part[k], r.weight);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // APB register writes, driven at the falling edge. Both sides are idle.
  // ---------------------------------------------------------------------
  task automatic write_reg(input reg_idx_e idx, input logic [8:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx <= REG_MASK_Z) mask_w[int'(idx)] = value;
    else zero_n[int'(idx) - 3] = value;
  endtask

  task automatic set_masks(input logic [8:0] mx, my, mz, zx, zy, zz);
    write_reg(REG_MASK_X, mx);
    write_reg(REG_MASK_Y, my);
    write_reg(REG_MASK_Z, mz);
    write_reg(REG_ZERO_X, zx);
    write_reg(REG_ZERO_Y, zy);
    write_reg(REG_ZERO_Z, zz);
  endtask

  // Waits until every expected beat has come back, then lets the pipeline run
  // dry before the registers change.
  task automatic drain;
    wait (expected_beats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Often no gap, a short gap otherwise, and an occasional long one.
  function automatic int pick_gap;
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drives one element beat and records the predicted result once accepted.
  // Starts and returns at a falling edge. Valid stays high on return so the
  // next beat can follow with no gap; stop_elems ends a burst.
  task automatic send_elem(input elem_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.index_x <= e.ix;
    elem_ch.index_y <= e.iy;
    elem_ch.index_z <= e.iz;
    elem_ch.real_x <= e.part[0];
    elem_ch.imag_x <= e.part[1];
    elem_ch.real_y <= e.part[2];
    elem_ch.imag_y <= e.part[3];
    elem_ch.real_z <= e.part[4];
    elem_ch.imag_z <= e.part[5];
    do @(posedge clk_i); while (!elem_ch.ready);
    expected_beats.push_back(predict_scaled(e));
    elems_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid after the last beat of a burst, at the falling edge where
  // send_elem returned.
  task automatic stop_elems;
    elem_ch.valid <= 1'b0;
  endtask

  // Random Q16.16 part biased toward extremes and small values.
  function automatic logic [31:0] rand_part;
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(70000)) - 32'd35000;
      default: return $urandom();
    endcase
  endfunction

  // Index near the band edges of the current settings most of the time.
  function automatic logic [7:0] rand_index(input int grid, input int axis);
    int c, span;
    c = grid / 2;
    span = (int'(mask_w[axis]) + int'(zero_n[axis])) / 2 + 3;
    if ($urandom_range(3) == 0) return 8'($urandom());
    return 8'(c - span + int'($urandom_range(2 * span)));
  endfunction

  function automatic elem_t rand_elem;
    elem_t e;
    e.ix = rand_index(GRID_X, 0);
    e.iy = rand_index(GRID_Y, 1);
    e.iz = ($urandom_range(7) == 0) ? 8'($urandom()) : 8'($urandom_range(128));
    if ($urandom_range(3) != 0) e.iz = 8'(rand_index(GRID_Z, 2) % 129);
    foreach (e.part[k]) e.part[k] = rand_part();
    return e;
  endfunction

  function automatic elem_t make_elem(input logic [7:0] x, y, z, input logic [31:0] v);
    elem_t e;
    e.ix = x; e.iy = y; e.iz = z;
    foreach (e.part[k]) e.part[k] = (k % 2 == 1) ? -v : v;
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, and the checker.
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    scaled_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        scaled_ch.ready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          scaled_ch.ready <= 1'b1;
        end else begin
          scaled_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
          scaled_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Holds the result side off for a long stretch while the sender keeps
  // offering beats, so the pipeline fills and input ready drops.
  initial begin
    wait (elems_sent > 600);
    long_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold = 1'b0;
    hold_done = 1'b1;
  end

  always @(posedge clk_i) begin
    scaled_t got, exp_b;
    bit bad;
    if (rst_ni && scaled_ch.valid && scaled_ch.ready) begin
      got.part[0] = scaled_ch.out_real_x;
      got.part[1] = scaled_ch.out_imag_x;
      got.part[2] = scaled_ch.out_real_y;
      got.part[3] = scaled_ch.out_imag_y;
      got.part[4] = scaled_ch.out_real_z;
      got.part[5] = scaled_ch.out_imag_z;
      got.weight = scaled_ch.total_weight;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: result beat with none expected");
      end else begin
        exp_b = expected_beats.pop_front();
        bad = got.weight !== exp_b.weight;
        foreach (got.part[k]) if (got.part[k] !== exp_b.part[k]) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: beat %0d weight exp %0d got %0d parts exp %p got %p",
                     beats_checked, exp_b.weight, got.weight, exp_b.part, got.part);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------
  row_t dir_rows [$];

  initial begin
    row_t row;
    elem_t e;
    scaled_t exp_b;
    elem_ch.valid = 1'b0;
    elem_ch.index_x = '0; elem_ch.index_y = '0; elem_ch.index_z = '0;
    elem_ch.real_x = '0; elem_ch.imag_x = '0; elem_ch.real_y = '0;
    elem_ch.imag_y = '0; elem_ch.real_z = '0; elem_ch.imag_z = '0;
    foreach (mask_w[a]) begin
      mask_w[a] = '0;
      zero_n[a] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // After reset every axis is disabled, so the weight is exactly one.
    row.has_weight = 1'b1; row.weight = ONE_Q15;
    row.elem = make_elem(8'd0, 8'd0, 8'd0, 32'h7fff_ffff); dir_rows.push_back(row);
    row.elem = make_elem(8'd255, 8'd255, 8'd255, 32'h8000_0000); dir_rows.push_back(row);
    row.elem = make_elem(8'd128, 8'd128, 8'd64, 32'hffff_ffff); dir_rows.push_back(row);
    foreach (dir_rows[r]) begin
      send_elem(dir_rows[r].elem);
    end
    stop_elems();
    drain();

    // Typical band: zero band and tapers. Rows inside the zero band have
    // weight zero; the rest go through the predictor.
    set_masks(9'd40, 9'd20, 9'd30, 9'd10, 9'd4, 9'd6);
    dir_rows.delete();
    row.has_weight = 1'b1; row.weight = 16'd0;
    row.elem = make_elem(8'd128, 8'd0, 8'd0, 32'h0001_0000); dir_rows.push_back(row);
    row.elem = make_elem(8'd0, 8'd126, 8'd0, 32'h7fff_ffff); dir_rows.push_back(row);
    row.elem = make_elem(8'd0, 8'd0, 8'd62, 32'h8000_0000); dir_rows.push_back(row);
    row.has_weight = 1'b0;
    row.elem = make_elem(8'd108, 8'd118, 8'd49, 32'h7fff_ffff); dir_rows.push_back(row);
    row.elem = make_elem(8'd110, 8'd120, 8'd55, 32'h8000_0000); dir_rows.push_back(row);
    row.elem = make_elem(8'd123, 8'd124, 8'd61, 32'h0000_8000); dir_rows.push_back(row);
    row.elem = make_elem(8'd133, 8'd130, 8'd70, 32'h0000_0001); dir_rows.push_back(row);
    row.elem = make_elem(8'd147, 8'd137, 8'd128, 32'h1234_5678); dir_rows.push_back(row);
    row.elem = make_elem(8'd160, 8'd139, 8'd255, 32'hffff_8000); dir_rows.push_back(row);
    foreach (dir_rows[r]) begin
      if (dir_rows[r].has_weight) begin
        exp_b = predict_scaled(dir_rows[r].elem);
        if (exp_b.weight !== dir_rows[r].weight) begin
          mismatch_count++;
          $display("ERROR: directed row %0d weight table %0d predictor %0d",
                   r, dir_rows[r].weight, exp_b.weight);
        end
      end
      send_elem(dir_rows[r].elem);
    end
    stop_elems();
    drain();

    // Zero count above mask width leaves only the zero band; large register
    // values cover whole axes and reach past the grid.
    set_masks(9'd8, 9'd511, 9'd256, 9'd20, 9'd0, 9'd256);
    for (int k = 0; k < 8; k++) begin
      e = make_elem(8'(118 + 3 * k), 8'(32 * k), 8'(16 * k), 32'h0003_0000 + 32'(k));
      send_elem(e);
    end
    stop_elems();
    drain();

    // Random phases, each under its own settings, ending on the extremes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_masks(9'd256, 9'd256, 9'd256, 9'd0, 9'd0, 9'd0);
        1: set_masks(9'd1, 9'd2, 9'd3, 9'd1, 9'd0, 9'd2);
        5: set_masks(9'd511, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);
        default: set_masks(9'($urandom_range(300)), 9'($urandom_range(300)),
                           9'($urandom_range(300)), 9'($urandom_range(120)),
                           9'($urandom_range(120)), 9'($urandom_range(120)));
      endcase
      for (int k = 0; k < N_RANDOM / 6; k++) send_elem(rand_elem());
      stop_elems();
      if (ph == 2) wait (hold_done);
      drain();
    end

    $display("Covered %0d element beats across nine register settings, %0d results checked,",
             elems_sent, beats_checked);
    $display("including a 300 cycle result hold-off that backed up the input.");
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", mismatch_count,
               expected_beats.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sbtm_pkg.sv
hw/rtl/sbtm_if.sv
hw/rtl/sbtm_cfg.sv
hw/rtl/sbtm_axis_lane.sv
hw/rtl/sbtm_merge.sv
hw/rtl/spectral_band_taper_mask.sv
sim/tb_spectral_band_taper_mask.sv
